### rtl/h3df_pkg.sv
// ----------------------------------------------------------------------------
// h3df_pkg
// Shared types and codes of the HTTP/3 frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package h3df_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned VarintW  = 62;
	localparam int unsigned LeftW    = 3;

	localparam logic [1:0] PH_TYPE    = 2'd0;
	localparam logic [1:0] PH_LEN     = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_HEADERS = 2'd1;
	localparam logic [1:0] KIND_OTHER   = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] stream_byte;
	} in_item_t;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] payload_byte;
		logic             frame_kind;
		logic             frame_end;
	} res_item_t;

endpackage

`default_nettype wire

### rtl/h3df_in_stage.sv
// ----------------------------------------------------------------------------
// h3df_in_stage
// Input register: holds one accepted stream byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module h3df_in_stage
	import h3df_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [ByteW-1:0] s_tdata,
	input  wire logic             advance,
	output in_item_t              item_s1
);

	logic             valid_s1;
	logic [ByteW-1:0] data_s1;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	assign item_s1.valid       = valid_s1;
	assign item_s1.stream_byte = data_s1;

endmodule

`default_nettype wire

### rtl/h3df_parse.sv
// ----------------------------------------------------------------------------
// h3df_parse
// Frame parser: varint gathering for type and length, payload counting.
// ----------------------------------------------------------------------------
`default_nettype none

module h3df_parse
	import h3df_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t item_s1,
	input  wire logic     advance,
	output res_item_t     res
);

	logic [1:0]         phase_q;
	logic [LeftW-1:0]   vleft_q;
	logic [VarintW-1:0] vvalue_q;
	logic [1:0]         kind_q;
	logic [VarintW-1:0] pleft_q;

	logic [LeftW-1:0]   vleft_d;
	logic [VarintW-1:0] vvalue_d;
	logic               vdone;
	logic               vzero;
	logic [VarintW-1:0] pleft_dec;
	logic               plast;
	logic [ByteW-1:0]   b;

	assign b = item_s1.stream_byte;

	always_comb begin
		if (vleft_q == '0) begin
			vvalue_d = {{(VarintW-6){1'b0}}, b[5:0]};
			case (b[7:6])
				2'd0:    vleft_d = LeftW'(0);
				2'd1:    vleft_d = LeftW'(1);
				2'd2:    vleft_d = LeftW'(3);
				default: vleft_d = LeftW'(7);
			endcase
		end else begin
			vvalue_d = {vvalue_q[VarintW-ByteW-1:0], b};
			vleft_d  = vleft_q - LeftW'(1);
		end
	end

	assign vdone     = (vleft_d == '0);
	assign vzero     = (vvalue_d == '0);
	assign pleft_dec = pleft_q - VarintW'(1);
	assign plast     = (pleft_dec == '0);

	always_comb begin
		res.valid        = advance && (phase_q == PH_PAYLOAD) && !kind_q[1];
		res.payload_byte = b;
		res.frame_kind   = kind_q[0];
		res.frame_end    = plast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			vleft_q  <= '0;
			vvalue_q <= '0;
			kind_q   <= KIND_DATA;
			pleft_q  <= '0;
		end else if (advance) begin
			case (phase_q)
				PH_PAYLOAD: begin
					pleft_q <= pleft_dec;
					if (plast) begin
						phase_q <= PH_TYPE;
					end
				end
				PH_LEN: begin
					vleft_q  <= vleft_d;
					vvalue_q <= vvalue_d;
					if (vdone) begin
						if (vzero) begin
							phase_q <= PH_TYPE;
						end else begin
							pleft_q <= vvalue_d;
							phase_q <= PH_PAYLOAD;
						end
					end
				end
				default: begin
					vleft_q  <= vleft_d;
					vvalue_q <= vvalue_d;
					phase_q  <= PH_TYPE;
					if (vdone) begin
						if (vzero) begin
							kind_q <= KIND_DATA;
						end else if (vvalue_d == VarintW'(1)) begin
							kind_q <= KIND_HEADERS;
						end else begin
							kind_q <= KIND_OTHER;
						end
						phase_q <= PH_LEN;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/h3df_out_stage.sv
// ----------------------------------------------------------------------------
// h3df_out_stage
// Result register towards the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module h3df_out_stage
	import h3df_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire res_item_t  res,
	output logic            free,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [ByteW-1:0] m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);

	logic             valid_q;
	logic [ByteW-1:0] data_q;
	logic             kind_q;
	logic             last_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res.valid) begin
			data_q <= res.payload_byte;
			kind_q <= res.frame_kind;
			last_q <= res.frame_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

### rtl/http3_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// http3_frame_deframer_core
// Splits a received HTTP/3 byte stream into frames and passes on the payload
// bytes of DATA and HEADERS frames.
//
// The slave-side stream carries one stream byte per transaction. Frame type
// and frame length are read as QUIC variable-length integers; the payload
// bytes of DATA and HEADERS frames leave on the master-side stream, with the
// frame kind on tuser and tlast on the final byte of each frame. Type bytes,
// length bytes and payload of any other frame type produce no transaction.
// An accepted byte waits in the input register and is parsed into the
// result register once that register is free. While the receiver does not
// stall, one byte is accepted per cycle, set by the single parser stage
// between the input and result registers. When the receiver stalls, the
// result register holds its transaction and the input register still takes
// one more byte; tready then drops until the result is taken. Reset empties
// both registers and returns the parser to reading a frame type.
// ----------------------------------------------------------------------------
`default_nettype none

module http3_frame_deframer_core
	import h3df_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [ByteW-1:0] s_tdata,   // [7:0] stream_byte
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [ByteW-1:0]      m_tdata,   // [7:0] payload_byte
	output logic                  m_tuser,   // [0] frame_kind
	output logic                  m_tlast
);

	in_item_t  item_s1;
	res_item_t res;
	logic      free;
	logic      advance;

	assign advance = item_s1.valid && free;

	h3df_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	h3df_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.res     (res)
	);

	h3df_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### rtl/h3df_checker.sv
// ----------------------------------------------------------------------------
// h3df_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module h3df_checker
	import h3df_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [ByteW-1:0] m_tdata,
	input wire logic             m_tuser,
	input wire logic             m_tlast
);

	// With the result register empty the block always takes a byte.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("s_tready low with empty result register");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("s_tready low while the receiver takes data");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped during a stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			$stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("master-side transaction changed during a stall");

endmodule

bind http3_frame_deframer_core h3df_checker u_h3df_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
